>>> rtl/sam_pkg.sv
// Shared types and constants for the sepia / mirror pixel stream block.
// No dependencies; imported by every other file of the block.
package sam_pkg;

  localparam int PIX_W  = 24;
  localparam int CH_W   = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 16;
  localparam int CFG_W  = 16;
  localparam int WGT_W  = 10;
  localparam int SUM_W  = 19;
  localparam int RCP_W  = 19;
  localparam int PROD_W = SUM_W + RCP_W;
  localparam int QUO_W  = 9;

  // floor(s/1000) == (s * RECIP_1000) >> RECIP_SHIFT for every sum up to 1351*255
  localparam int RECIP_SHIFT = 28;
  localparam logic [RCP_W-1:0] RECIP_1000 = 19'd268436;
  localparam logic [CH_W-1:0]  CH_MAX     = 8'd255;

  typedef logic [WGT_W-1:0] wgt_t;

  localparam wgt_t SEPIA_WGT [0:2][0:2] = '{
    '{10'd393, 10'd769, 10'd189},
    '{10'd349, 10'd686, 10'd168},
    '{10'd272, 10'd534, 10'd131}
  };

  typedef enum logic [1:0] {
    CFG_SEPIA  = 2'd0,
    CFG_MIRROR = 2'd1,
    CFG_WIDTH  = 2'd2,
    CFG_ROWS   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic capture;
    logic sum;
    logic div;
    logic store;
    logic col_next;
    logic row_next;
    logic rd_load;
    logic read;
    logic rd_dec;
    logic out_load;
    logic out_sel_mem;
  } sam_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic mirror_en;
    logic last_col;
    logic out_free;
    logic rd_zero;
  } sam_sts_t;

endpackage

>>> rtl/sam_if.sv
// Handshake channel interfaces: pixel input, pixel result, register write.
// Depends on sam_pkg for widths.
interface sam_pix_in_if import sam_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] in_red;
  logic [CH_W-1:0] in_green;
  logic [CH_W-1:0] in_blue;

  modport source (output valid, output in_red, output in_green, output in_blue, input ready);
  modport sink   (input valid, input in_red, input in_green, input in_blue, output ready);
endinterface

interface sam_pix_out_if import sam_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;
  logic            row_end;
  logic            frame_end;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output row_end, output frame_end, input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input row_end, input frame_end, output ready);
endinterface

interface sam_cfg_if import sam_pkg::*; ();
  logic             valid;
  logic             ready;
  cfg_idx_t         index;
  logic [CFG_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/sam_ctrl.sv
// Sequencing state machine: accept, sepia sum, divide, decide, reversed readout.
// Depends on sam_pkg; drives sam_dp through sam_cmd_t.
module sam_ctrl import sam_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  sam_sts_t sts,
  output logic     in_ready,
  output sam_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_DECIDE,
    ST_RD,
    ST_LOAD
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.store = 1'b1;
        if (sts.mirror_en) begin
          if (sts.last_col) begin
            cmd.rd_load = 1'b1;
            state_nxt   = ST_RD;
          end else begin
            cmd.col_next = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end else if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.col_next = !sts.last_col;
          cmd.row_next = sts.last_col;
          state_nxt    = ST_IDLE;
        end
      end
      ST_RD: begin
        cmd.read  = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_sel_mem = 1'b1;
          if (sts.rd_zero) begin
            cmd.row_next = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            cmd.rd_dec = 1'b1;
            state_nxt  = ST_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/sam_dp.sv
// Datapath: config registers, sepia matrix, row store, counters, result register.
// Depends on sam_pkg; commanded by sam_ctrl.
module sam_dp import sam_pkg::*; #(
  parameter int MAX_WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  sam_cmd_t         cmd,
  output sam_sts_t         sts,
  input  logic             in_valid,
  input  logic [PIX_W-1:0] in_pix,
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [PIX_W-1:0] out_pix,
  output logic             out_row_end,
  output logic             out_frame_end
);

  localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam logic [COL_W-1:0] MAX_COL = COL_W'(MAX_WIDTH - 1);
  localparam logic [COL_W-1:0] MAX_W   = COL_W'(MAX_WIDTH);

  logic             sepia_en_r;
  logic             mirror_en_r;
  logic [COL_W-1:0] row_width_r;
  logic [ROW_W-1:0] frame_rows_r;

  logic [PIX_W-1:0] pix_r;
  logic [SUM_W-1:0] sum_r [0:2];
  logic [PIX_W-1:0] px_r;
  logic [PIX_W-1:0] row_store [0:MAX_WIDTH-1];
  logic [PIX_W-1:0] rd_data_r;
  logic [ADDR_W-1:0] rd_idx_r;
  logic [COL_W-1:0] column_count_r;
  logic [ROW_W-1:0] row_count_r;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_pix_r;
  logic             out_row_end_r;
  logic             out_frame_end_r;

  logic [COL_W-1:0] width_eff;
  logic [ROW_W-1:0] rows_eff;
  logic [COL_W-1:0] col;
  logic             last_col;
  logic             last_row;
  logic             rd_zero;
  logic             out_free;
  logic [CH_W-1:0]  sep_ch [0:2];
  logic [SUM_W-1:0] sum_nxt [0:2];
  logic [PROD_W-1:0] prod [0:2];
  logic [QUO_W-1:0] quo [0:2];

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sepia_en_r   <= 1'b0;
      mirror_en_r  <= 1'b0;
      row_width_r  <= MAX_W;
      frame_rows_r <= ROW_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEPIA:  sepia_en_r   <= cfg_data[0];
        CFG_MIRROR: mirror_en_r  <= cfg_data[0];
        CFG_WIDTH:  row_width_r  <= cfg_data[COL_W-1:0];
        CFG_ROWS:   frame_rows_r <= cfg_data[ROW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (row_width_r == '0) begin
      width_eff = COL_W'(1);
    end else if (row_width_r > MAX_W) begin
      width_eff = MAX_W;
    end else begin
      width_eff = row_width_r;
    end
    rows_eff = (frame_rows_r == '0) ? ROW_W'(1) : frame_rows_r;
    col      = (column_count_r > MAX_COL) ? MAX_COL : column_count_r;
    last_col = col >= (width_eff - COL_W'(1));
    last_row = row_count_r >= (rows_eff - ROW_W'(1));
    rd_zero  = rd_idx_r == '0;
    out_free = !out_valid_r || out_ready;
  end

  // sepia: weighted sums, then divide by 1000 through a reciprocal multiply
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_nxt[k] = SUM_W'(SEPIA_WGT[k][0]) * SUM_W'(pix_r[23:16])
                 + SUM_W'(SEPIA_WGT[k][1]) * SUM_W'(pix_r[15:8])
                 + SUM_W'(SEPIA_WGT[k][2]) * SUM_W'(pix_r[7:0]);
      prod[k]    = PROD_W'(sum_r[k]) * PROD_W'(RECIP_1000);
      quo[k]     = prod[k][RECIP_SHIFT +: QUO_W];
      sep_ch[k]  = (quo[k] > QUO_W'(CH_MAX)) ? CH_MAX : quo[k][CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pix_r <= in_pix;
    end
    if (cmd.sum) begin
      for (int k = 0; k < 3; k++) begin
        sum_r[k] <= sum_nxt[k];
      end
    end
    if (cmd.div) begin
      px_r <= sepia_en_r ? {sep_ch[0], sep_ch[1], sep_ch[2]} : pix_r;
    end
  end

  // row store
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      row_store[col[ADDR_W-1:0]] <= px_r;
    end
    if (cmd.read) begin
      rd_data_r <= row_store[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_load) begin
      rd_idx_r <= col[ADDR_W-1:0];
    end else if (cmd.rd_dec) begin
      rd_idx_r <= rd_idx_r - ADDR_W'(1);
    end
  end

  // column and row position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= '0;
      row_count_r    <= '0;
    end else if (cmd.row_next) begin
      column_count_r <= '0;
      row_count_r    <= last_row ? '0 : row_count_r + ROW_W'(1);
    end else if (cmd.col_next) begin
      column_count_r <= col + COL_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_sel_mem) begin
        out_pix_r       <= rd_data_r;
        out_row_end_r   <= rd_zero;
        out_frame_end_r <= rd_zero && last_row;
      end else begin
        out_pix_r       <= px_r;
        out_row_end_r   <= last_col;
        out_frame_end_r <= last_col && last_row;
      end
    end
  end

  assign sts.in_valid  = in_valid;
  assign sts.mirror_en = mirror_en_r;
  assign sts.last_col  = last_col;
  assign sts.out_free  = out_free;
  assign sts.rd_zero   = rd_zero;

  assign out_valid     = out_valid_r;
  assign out_pix       = out_pix_r;
  assign out_row_end   = out_row_end_r;
  assign out_frame_end = out_frame_end_r;

endmodule

>>> rtl/sepia_and_mirror_pixel_stream.sv
// Top level: sepia tone filter with horizontal row mirror on an RGB stream.
// Depends on sam_pkg, sam_if, sam_ctrl, sam_dp.
//
//   port     dir  transfer moves
//   in_px    in   one RGB pixel (in_red, in_green, in_blue)
//   out_px   out  one RGB pixel with row_end and frame_end
//   cfg_wr   in   register write: index, data (always ready)
//
// A pixel passes in turn through accept, weighted sum, reciprocal divide and store/decide.
// A mirrored row of w pixels is emitted in reverse order: each pixel goes through a
// registered read of the row store, then the result register.
// Reset clears config, counters and the state machine; row store contents are not reset.
// A stalled result holds in the output register; the block then waits at decide/load.
module sepia_and_mirror_pixel_stream import sam_pkg::*; #(
  parameter int MAX_WIDTH = 64
) (
  input logic         clk,
  input logic         rst_n,
  sam_pix_in_if.sink  in_px,
  sam_pix_out_if.source out_px,
  sam_cfg_if.sink     cfg_wr
);

  sam_cmd_t         cmd;
  sam_sts_t         sts;
  logic             in_ready;
  logic [PIX_W-1:0] out_pix;

  assign in_px.ready  = in_ready;
  assign cfg_wr.ready = 1'b1;

  sam_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  sam_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_valid      (in_px.valid),
    .in_pix        ({in_px.in_red, in_px.in_green, in_px.in_blue}),
    .cfg_we        (cfg_wr.valid),
    .cfg_index     (cfg_wr.index),
    .cfg_data      (cfg_wr.data),
    .out_ready     (out_px.ready),
    .out_valid     (out_px.valid),
    .out_pix       (out_pix),
    .out_row_end   (out_px.row_end),
    .out_frame_end (out_px.frame_end)
  );

  assign out_px.out_red   = out_pix[23:16];
  assign out_px.out_green = out_pix[15:8];
  assign out_px.out_blue  = out_pix[7:0];

endmodule

>>> tb/sv/sam_pixel_check.sv
// Watches the pixel, result and register-write channels of the sepia / mirror
// block, predicts every result pixel and compares them in order.
// Depends on sam_pkg for widths and register indexes.
module sam_pixel_check import sam_pkg::*; #(
  parameter int MAX_W = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [CH_W-1:0]  in_red,
  input  logic [CH_W-1:0]  in_green,
  input  logic [CH_W-1:0]  in_blue,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [CH_W-1:0]  out_red,
  input  logic [CH_W-1:0]  out_green,
  input  logic [CH_W-1:0]  out_blue,
  input  logic             row_end,
  input  logic             frame_end,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  cfg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int unsigned      fail_count,
  output int unsigned      results_left,
  output int unsigned      results_checked
);

  localparam int IDX_W = (MAX_W > 1) ? $clog2(MAX_W) : 1;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            row_end;
    logic            frame_end;
  } result_px_t;

  result_px_t       expected_px [$];
  result_px_t       want;
  logic [PIX_W-1:0] row_copy [0:MAX_W-1];
  logic [COL_W-1:0] col_now;
  logic [ROW_W-1:0] row_now;
  logic             sepia_on;
  logic             mirror_on;
  logic [COL_W-1:0] width_reg;
  logic [ROW_W-1:0] rows_reg;

  function automatic logic [CH_W-1:0] per_mille_clip(input int unsigned acc);
    int unsigned q;
    q = acc / 1000;
    return (q > 255) ? 8'hFF : q[CH_W-1:0];
  endfunction

  task automatic predict_pixel(input logic [CH_W-1:0] r, g, b);
    int unsigned      w;
    int unsigned      fr;
    int unsigned      col;
    logic [PIX_W-1:0] px;
    logic             last_col;
    logic             last_row;
    w = (width_reg == 0) ? 1 : width_reg;
    if (w > MAX_W) w = MAX_W;
    fr = (rows_reg == 0) ? 1 : rows_reg;
    if (sepia_on) begin
      px = {per_mille_clip(393 * r + 769 * g + 189 * b),
            per_mille_clip(349 * r + 686 * g + 168 * b),
            per_mille_clip(272 * r + 534 * g + 131 * b)};
    end else begin
      px = {r, g, b};
    end
    col = (col_now >= MAX_W) ? MAX_W - 1 : col_now;
    row_copy[IDX_W'(col)] = px;
    last_col = (col >= w - 1);
    last_row = (row_now >= fr - 1);
    if (!last_col) begin
      col_now = COL_W'(col + 1);
      if (!mirror_on) expected_px.push_back({px, 1'b0, 1'b0});
    end else begin
      if (mirror_on) begin
        for (int i = col; i >= 0; i--)
          expected_px.push_back({row_copy[IDX_W'(i)], i == 0, (i == 0) && last_row});
      end else begin
        expected_px.push_back({px, 1'b1, last_row});
      end
      col_now = '0;
      row_now = last_row ? '0 : row_now + 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_px.delete();
      col_now = '0;
      row_now = '0;
      sepia_on = 1'b0;
      mirror_on = 1'b0;
      width_reg = MAX_W;
      rows_reg = 1;
      fail_count = 0;
      results_checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SEPIA:  sepia_on = cfg_data[0];
          CFG_MIRROR: mirror_on = cfg_data[0];
          CFG_WIDTH:  width_reg = cfg_data[COL_W-1:0];
          CFG_ROWS:   rows_reg = cfg_data[ROW_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_pixel(in_red, in_green, in_blue);
      if (out_valid && out_ready) begin
        if (expected_px.size() == 0) begin
          $error("result transfer with no pixel expected");
          fail_count++;
        end else begin
          want = expected_px.pop_front();
          results_checked++;
          if (out_red !== want.red) begin
            $error("out_red: expected %0d, got %0d", want.red, out_red);
            fail_count++;
          end
          if (out_green !== want.green) begin
            $error("out_green: expected %0d, got %0d", want.green, out_green);
            fail_count++;
          end
          if (out_blue !== want.blue) begin
            $error("out_blue: expected %0d, got %0d", want.blue, out_blue);
            fail_count++;
          end
          if (row_end !== want.row_end) begin
            $error("row_end: expected %0d, got %0d", want.row_end, row_end);
            fail_count++;
          end
          if (frame_end !== want.frame_end) begin
            $error("frame_end: expected %0d, got %0d", want.frame_end, frame_end);
            fail_count++;
          end
        end
      end
    end
    results_left = expected_px.size();
  end

endmodule

>>> tb/sv/sepia_and_mirror_pixel_stream_tb.sv
// Top of the sepia / mirror pixel stream testbench: clock, reset, register
// settings, pixel stimulus with random gaps and stalls, and the verdict.
// Depends on sam_pkg, sam_if, the block itself and sam_pixel_check.
module sepia_and_mirror_pixel_stream_tb;
  import sam_pkg::*;

  localparam int MAX_W      = 64;
  localparam int LIMIT      = 150000;
  localparam int SETTLE     = 16;
  localparam int HOLD       = 150;
  localparam int ROW_BUDGET = 20;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned results_left;
  int unsigned results_checked;
  int unsigned cycle_count = 0;
  int unsigned pixels_sent = 0;
  int unsigned settings_used = 0;
  int          in_idle_pct;
  int          out_idle_pct;
  logic        hold_req;
  logic        hold_seen;
  int          stall_left;

  sam_pix_in_if  in_px ();
  sam_pix_out_if out_px ();
  sam_cfg_if     cfg_wr ();

  sepia_and_mirror_pixel_stream #(.MAX_WIDTH(MAX_W)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_px  (in_px),
    .out_px (out_px),
    .cfg_wr (cfg_wr)
  );

  sam_pixel_check #(.MAX_W(MAX_W)) pixel_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_px.valid),
    .in_ready        (in_px.ready),
    .in_red          (in_px.in_red),
    .in_green        (in_px.in_green),
    .in_blue         (in_px.in_blue),
    .out_valid       (out_px.valid),
    .out_ready       (out_px.ready),
    .out_red         (out_px.out_red),
    .out_green       (out_px.out_green),
    .out_blue        (out_px.out_blue),
    .row_end         (out_px.row_end),
    .frame_end       (out_px.frame_end),
    .cfg_valid       (cfg_wr.valid),
    .cfg_ready       (cfg_wr.ready),
    .cfg_index       (cfg_wr.index),
    .cfg_data        (cfg_wr.data),
    .fail_count      (fail_count),
    .results_left    (results_left),
    .results_checked (results_checked)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off on each toggle of hold_req
  initial begin
    out_px.ready = 1'b0;
    hold_seen = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        stall_left = HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_px.ready <= 1'b0;
      end else begin
        out_px.ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  function automatic logic [CH_W-1:0] rand_ch();
    return CH_W'($urandom_range(255));
  endfunction

  task automatic set_config(input logic sep, input logic mir,
                            input logic [COL_W-1:0] w, input logic [ROW_W-1:0] rows);
    cfg_idx_t         idx;
    logic [CFG_W-1:0] vals [0:3];
    vals[CFG_SEPIA]  = CFG_W'(sep);
    vals[CFG_MIRROR] = CFG_W'(mir);
    vals[CFG_WIDTH]  = CFG_W'(w);
    vals[CFG_ROWS]   = rows;
    idx = CFG_SEPIA;
    repeat (4) begin
      cfg_wr.valid <= 1'b1;
      cfg_wr.index <= idx;
      cfg_wr.data  <= vals[idx];
      do @(posedge clk); while (!cfg_wr.ready);
      @(negedge clk);
      idx = idx.next();
    end
    cfg_wr.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic send_pixel(input logic [CH_W-1:0] r, g, b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_px.valid <= 1'b0;
      @(negedge clk);
    end
    in_px.valid    <= 1'b1;
    in_px.in_red   <= r;
    in_px.in_green <= g;
    in_px.in_blue  <= b;
    do @(posedge clk); while (!in_px.ready);
    @(negedge clk);
    pixels_sent++;
  endtask

  // block idle: nothing pending, then room for a withheld pixel to finish
  task automatic drain();
    in_px.valid <= 1'b0;
    while (results_left != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    int               seg;
    int               n;
    int               weff;
    logic             sep;
    logic             mir;
    logic [COL_W-1:0] w;
    logic [ROW_W-1:0] rows;

    rst_n = 1'b0;
    in_px.valid = 1'b0;
    in_px.in_red = '0;
    in_px.in_green = '0;
    in_px.in_blue = '0;
    cfg_wr.valid = 1'b0;
    cfg_wr.index = CFG_SEPIA;
    cfg_wr.data = '0;
    in_idle_pct = 17;
    out_idle_pct = 58;
    hold_req = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // sepia extremes, two rows of four, frame end on the second
    set_config(1'b1, 1'b0, 4, 2);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd170, 8'd85, 8'd51);
    send_pixel(8'd85, 8'd170, 8'd204);
    send_pixel(8'd1, 8'd128, 8'd254);
    drain();
    // mirror, zero frame rows
    set_config(1'b0, 1'b1, 3, 0);
    repeat (6) send_pixel(rand_ch(), rand_ch(), rand_ch());
    drain();
    // mirror dropped mid-row: withheld pixels are lost
    set_config(1'b1, 1'b1, 5, 1);
    repeat (2) send_pixel(rand_ch(), rand_ch(), rand_ch());
    drain();
    set_config(1'b1, 1'b0, 5, 1);
    repeat (3) send_pixel(rand_ch(), rand_ch(), rand_ch());
    drain();
    // width shrinks mid-row
    set_config(1'b0, 1'b1, 8, 3);
    repeat (3) send_pixel(rand_ch(), rand_ch(), rand_ch());
    drain();
    set_config(1'b0, 1'b1, 2, 3);
    send_pixel(rand_ch(), rand_ch(), rand_ch());
    drain();
    // zero width
    set_config(1'b0, 1'b0, 0, 1);
    repeat (2) send_pixel(rand_ch(), rand_ch(), rand_ch());

    for (seg = 0; seg < 12; seg++) begin
      if (seg == 4) begin
        in_idle_pct <= 58;
        out_idle_pct <= 17;
      end else if (seg == 8) begin
        in_idle_pct <= 0;
        out_idle_pct <= 0;
      end
      drain();
      sep = 1'($urandom_range(1));
      mir = 1'($urandom_range(1));
      w = ($urandom_range(3) == 0) ? COL_W'($urandom_range(127))
                                   : COL_W'($urandom_range(12, 1));
      rows = ROW_W'($urandom_range(5));
      case (seg)
        0:  begin sep = 1'b0; mir = 1'b1; w = 64;  rows = 1;     end
        1:  begin sep = 1'b1; mir = 1'b0; w = 1;   rows = 3;     end
        2:  begin sep = 1'b1; mir = 1'b1; w = 7;   rows = 2;     end
        3:  begin sep = 1'b0; mir = 1'b0; w = 0;   rows = 0;     end
        4:  begin sep = 1'b1; mir = 1'b1; w = 127; rows = 16'hFFFF; end
        6:  begin sep = 1'b0; mir = 1'b1; w = 2;   rows = 1;     end
        7:  begin sep = 1'b1; mir = 1'b1; w = 5;   rows = 4;     end
        9:  begin sep = 1'b0; mir = 1'b0; w = 8;   rows = 2;     end
        11: begin sep = 1'b1; mir = 1'b1; w = 64;  rows = 2;     end
        default: ;
      endcase
      set_config(sep, mir, w, rows);
      weff = (w == 0) ? 1 : (w > MAX_W) ? MAX_W : w;
      n = weff * ((ROW_BUDGET + weff - 1) / weff);
      // occasionally leave a row unfinished
      if ($urandom_range(4) == 0) n += $urandom_range(weff - 1);
      if (seg == 9) hold_req <= ~hold_req;
      for (int k = 0; k < n; k++) begin
        if (seg == 5 && k == n / 2) drain();
        send_pixel(rand_ch(), rand_ch(), rand_ch());
      end
    end
    drain();

    $display("Covered %0d pixels under %0d register settings: sepia, mirror, mid-row changes,",
             pixels_sent, settings_used);
    $display("widths 0..127 and frame counts 0..65535; %0d result pixels compared.",
             results_checked);
    if (fail_count == 0 && results_left == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sepia_and_mirror_pixel_stream.f
rtl/sam_pkg.sv
rtl/sam_if.sv
rtl/sam_ctrl.sv
rtl/sam_dp.sv
rtl/sepia_and_mirror_pixel_stream.sv
tb/sv/sam_pixel_check.sv
tb/sv/sepia_and_mirror_pixel_stream_tb.sv
